FILE: sv/key_state_autorepeat_tracker_core_macros.svh
// Assertion helpers shared by the RTL of the key state tracker.
`ifndef KEY_STATE_AUTOREPEAT_TRACKER_CORE_MACROS_SVH
`define KEY_STATE_AUTOREPEAT_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define KSAT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define KSAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KSAT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define KSAT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/ksat_pkg.sv
package ksat_pkg;

    localparam int KEY_W        = 7;
    localparam int CNT_W        = 5;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 7;
    localparam int DEF_NUM_KEYS = 128;

    localparam logic [CNT_W-1:0] DEF_REPEAT_DELAY  = 5'd18;
    localparam logic [CNT_W-1:0] DEF_REPEAT_PERIOD = 5'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRESS       = 3'd0,
        MODE_RELEASE     = 3'd1,
        MODE_FRAME_START = 3'd2,
        MODE_FRAME_END   = 3'd3,
        MODE_QUERY       = 3'd4
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY   = 3'd0,
        CFG_REPEAT_PERIOD  = 3'd1,
        CFG_MODIFIER_FIRST = 3'd2,
        CFG_MODIFIER_LAST  = 3'd3,
        CFG_MOUSE_FIRST    = 3'd4,
        CFG_MOUSE_LAST     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } in_item_t;

    typedef struct packed {
        logic is_down;
        logic is_pressed;
    } out_item_t;

endpackage

FILE: sv/key_state_autorepeat_tracker_core.sv
// Channel   Ports                      Carries
// input     s_valid s_ready s_item     mode, key
// result    m_valid m_ready m_item     is_down, is_pressed
// config    cfg_wr_en/index/data       six registers, one written per write strobe
//
// One item per cycle while results are taken: an input register, the bitmap update, a result register.
// An accepted item fills the input register, then moves into the result register, which raises result valid.
// Key bitmaps live in flops, so frame end copies the whole held bitmap into the previous one in a single update.
// A stalled result holds the pipe; the input register still fills once.
// aresetn is synchronous, active low; it clears bitmaps and restores defaults.
`include "key_state_autorepeat_tracker_core_macros.svh"

module key_state_autorepeat_tracker_core #(
    parameter int NUM_KEYS = ksat_pkg::DEF_NUM_KEYS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ksat_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ksat_pkg::out_item_t                 m_item,
    input  logic                                cfg_wr_en,
    input  logic [ksat_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [ksat_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import ksat_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CMP_W = (IDX_W + 1 > KEY_W) ? IDX_W + 1 : KEY_W;

    // configuration
    logic [CNT_W-1:0] repeat_delay_reg;
    logic [CNT_W-1:0] repeat_period_reg;
    logic [KEY_W-1:0] modifier_first_reg;
    logic [KEY_W-1:0] modifier_last_reg;
    logic [KEY_W-1:0] mouse_first_reg;
    logic [KEY_W-1:0] mouse_last_reg;

    // pipeline
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;
    logic      in_fire;

    // key state
    logic [NUM_KEYS-1:0] held_reg;
    logic [NUM_KEYS-1:0] held_next;
    logic [NUM_KEYS-1:0] prev_reg;
    logic [NUM_KEYS-1:0] prev_next;
    logic [KEY_W-1:0]    repeat_key_reg;
    logic [KEY_W-1:0]    repeat_key_next;
    logic                repeat_valid_reg;
    logic                repeat_valid_next;
    logic [CNT_W-1:0]    repeat_count_reg;
    logic [CNT_W-1:0]    repeat_count_next;

    logic [CMP_W-1:0] key_wide;
    logic [IDX_W-1:0] key_idx;
    logic             key_ok;
    logic             excluded;
    logic [CMP_W-1:0] rk_wide;
    logic [IDX_W-1:0] rk_idx;
    logic [CNT_W:0]   cnt_inc;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign in_fire = in_valid_reg && advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assign key_wide = CMP_W'(in_item_reg.key);
    assign key_idx  = key_wide[IDX_W-1:0];
    assign key_ok   = key_wide < CMP_W'(NUM_KEYS);
    assign rk_wide  = CMP_W'(repeat_key_reg);
    assign rk_idx   = rk_wide[IDX_W-1:0];
    assign excluded =
        (in_item_reg.key >= modifier_first_reg && in_item_reg.key <= modifier_last_reg) ||
        (in_item_reg.key >= mouse_first_reg && in_item_reg.key <= mouse_last_reg);

    always_comb begin
        held_next         = held_reg;
        prev_next         = prev_reg;
        repeat_key_next   = repeat_key_reg;
        repeat_valid_next = repeat_valid_reg;
        repeat_count_next = repeat_count_reg;
        cnt_inc           = {1'b0, repeat_count_reg} + (CNT_W+1)'(1);
        unique case (mode_e'(in_item_reg.mode))
            MODE_PRESS: begin
                if (key_ok) begin
                    if (!excluded && !prev_reg[key_idx]) begin
                        repeat_key_next   = in_item_reg.key;
                        repeat_valid_next = 1'b1;
                        repeat_count_next = '0;
                    end
                    held_next[key_idx] = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (key_ok) begin
                    held_next[key_idx] = 1'b0;
                end
            end
            MODE_FRAME_START: begin
                if (repeat_valid_reg && held_reg[rk_idx]) begin
                    // on reaching the delay, pull back by the period and re-arm the edge
                    if (cnt_inc >= {1'b0, repeat_delay_reg}) begin
                        if (cnt_inc > {1'b0, repeat_period_reg}) begin
                            cnt_inc = cnt_inc - {1'b0, repeat_period_reg};
                        end else begin
                            cnt_inc = '0;
                        end
                        prev_next[rk_idx] = 1'b0;
                    end
                    repeat_count_next = cnt_inc[CNT_W-1:0];
                end
            end
            MODE_FRAME_END: begin
                prev_next = held_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (key_ok) begin
            out_item_next.is_down    = held_next[key_idx];
            out_item_next.is_pressed = held_next[key_idx] && !prev_next[key_idx];
        end else begin
            out_item_next.is_down    = 1'b0;
            out_item_next.is_pressed = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_delay_reg   <= DEF_REPEAT_DELAY;
            repeat_period_reg  <= DEF_REPEAT_PERIOD;
            modifier_first_reg <= '0;
            modifier_last_reg  <= '0;
            mouse_first_reg    <= '0;
            mouse_last_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_wr_index))
                CFG_REPEAT_DELAY:   repeat_delay_reg   <= cfg_wr_data[CNT_W-1:0];
                CFG_REPEAT_PERIOD:  repeat_period_reg  <= cfg_wr_data[CNT_W-1:0];
                CFG_MODIFIER_FIRST: modifier_first_reg <= cfg_wr_data[KEY_W-1:0];
                CFG_MODIFIER_LAST:  modifier_last_reg  <= cfg_wr_data[KEY_W-1:0];
                CFG_MOUSE_FIRST:    mouse_first_reg    <= cfg_wr_data[KEY_W-1:0];
                CFG_MOUSE_LAST:     mouse_last_reg     <= cfg_wr_data[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_reg         <= '0;
            prev_reg         <= '0;
            repeat_key_reg   <= '0;
            repeat_valid_reg <= 1'b0;
            repeat_count_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_fire) begin
                held_reg         <= held_next;
                prev_reg         <= prev_next;
                repeat_key_reg   <= repeat_key_next;
                repeat_valid_reg <= repeat_valid_next;
                repeat_count_reg <= repeat_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (in_fire) begin
            out_item_reg <= out_item_next;
        end
    end

    `KSAT_ASSERT_SAME(a_pressed_implies_down, aclk, aresetn, out_valid_reg, !out_item_reg.is_pressed || out_item_reg.is_down)
    `KSAT_ASSERT_NEXT(a_press_sets_down, aclk, aresetn, in_fire && key_ok && in_item_reg.mode == MODE_PRESS, out_valid_reg && out_item_reg.is_down)
    `KSAT_ASSERT_NEXT(a_release_clears_down, aclk, aresetn, in_fire && in_item_reg.mode == MODE_RELEASE, out_valid_reg && !out_item_reg.is_down)
    `KSAT_ASSERT_NEXT(a_frame_end_no_edge, aclk, aresetn, in_fire && in_item_reg.mode == MODE_FRAME_END, held_reg == prev_reg && !out_item_reg.is_pressed)

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksat_pkg::*;

    localparam int N_KEYS = DEF_NUM_KEYS;
    localparam int STALL_LIMIT = 1000;
    localparam int N_PHASES = 7;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    key_state_autorepeat_tracker_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the tracker state and its registers
    logic [N_KEYS-1:0] held_bits = '0;
    logic [N_KEYS-1:0] prev_bits = '0;
    logic [KEY_W-1:0]  rpt_key = '0;
    logic              rpt_armed = 1'b0;
    logic [CNT_W-1:0]  rpt_count = '0;
    logic [CNT_W-1:0]  cfg_delay = DEF_REPEAT_DELAY;
    logic [CNT_W-1:0]  cfg_period = DEF_REPEAT_PERIOD;
    logic [KEY_W-1:0]  cfg_mod_lo = '0;
    logic [KEY_W-1:0]  cfg_mod_hi = '0;
    logic [KEY_W-1:0]  cfg_mouse_lo = '0;
    logic [KEY_W-1:0]  cfg_mouse_hi = '0;

    in_item_t  pending_items[$];
    out_item_t status_due[$];
    int        errors = 0;
    int        dead_cycles = 0;
    int        src_gap = 0;
    int        sink_gap = 0;
    logic      steady_flow = 1'b0;

    function automatic logic in_span(logic [KEY_W-1:0] k, logic [KEY_W-1:0] lo,
                                     logic [KEY_W-1:0] hi);
        return k >= lo && k <= hi;
    endfunction

    // Apply one item to the shadow state and return the key status it reports
    function automatic out_item_t key_status_after(in_item_t it);
        out_item_t  res;
        logic [5:0] cnt;
        logic       usable;
        usable = it.key < N_KEYS;
        case (it.mode)
            MODE_PRESS: begin
                if (usable) begin
                    if (!in_span(it.key, cfg_mod_lo, cfg_mod_hi) &&
                        !in_span(it.key, cfg_mouse_lo, cfg_mouse_hi) &&
                        !prev_bits[it.key]) begin
                        rpt_key = it.key;
                        rpt_armed = 1'b1;
                        rpt_count = '0;
                    end
                    held_bits[it.key] = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (usable)
                    held_bits[it.key] = 1'b0;
            end
            MODE_FRAME_START: begin
                if (rpt_armed && held_bits[rpt_key]) begin
                    cnt = rpt_count + 6'd1;
                    // fire a repeat: pull the count back and re-arm the press edge
                    if (cnt >= cfg_delay) begin
                        cnt = (cnt > cfg_period) ? cnt - cfg_period : 6'd0;
                        prev_bits[rpt_key] = 1'b0;
                    end
                    rpt_count = cnt[CNT_W-1:0];
                end
            end
            MODE_FRAME_END: prev_bits = held_bits;
            default: ;
        endcase
        res.is_down = usable && held_bits[it.key];
        res.is_pressed = usable && held_bits[it.key] && !prev_bits[it.key];
        return res;
    endfunction

    // Input driver: hold the item until its transfer, then advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                status_due.push_back(key_status_after(s_item));
            if (!s_valid || s_ready) begin
                if (!steady_flow && src_gap == 0 && $urandom_range(0, 15) == 0)
                    src_gap = $urandom_range(1, 17);
                if (src_gap > 0 || pending_items.size() == 0) begin
                    if (src_gap > 0)
                        src_gap--;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_item <= pending_items.pop_front();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!steady_flow && sink_gap == 0 && $urandom_range(0, 15) == 0)
            sink_gap = $urandom_range(1, 17);
        if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: is_down %0b is_pressed %0b",
                         $time, m_item.is_down, m_item.is_pressed);
            end else begin
                want = status_due.pop_front();
                if (m_item.is_down !== want.is_down) begin
                    errors++;
                    $display("%0t: is_down expected %0b got %0b",
                             $time, want.is_down, m_item.is_down);
                end
                if (m_item.is_pressed !== want.is_pressed) begin
                    errors++;
                    $display("%0t: is_pressed expected %0b got %0b",
                             $time, want.is_pressed, m_item.is_pressed);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial begin : watchdog
        wait (dead_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_item(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
        in_item_t it;
        it.mode = m;
        it.key = k;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(cfg_reg_e idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_REPEAT_DELAY:   cfg_delay = CNT_W'(val);
            CFG_REPEAT_PERIOD:  cfg_period = CNT_W'(val);
            CFG_MODIFIER_FIRST: cfg_mod_lo = KEY_W'(val);
            CFG_MODIFIER_LAST:  cfg_mod_hi = KEY_W'(val);
            CFG_MOUSE_FIRST:    cfg_mouse_lo = KEY_W'(val);
            CFG_MOUSE_LAST:     cfg_mouse_hi = KEY_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_settings(int delay, int period, int mod_lo, int mod_hi,
                                  int mouse_lo, int mouse_hi);
        write_reg(CFG_REPEAT_DELAY, delay);
        write_reg(CFG_REPEAT_PERIOD, period);
        write_reg(CFG_MODIFIER_FIRST, mod_lo);
        write_reg(CFG_MODIFIER_LAST, mod_hi);
        write_reg(CFG_MOUSE_FIRST, mouse_lo);
        write_reg(CFG_MOUSE_LAST, mouse_hi);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Sample on the falling edge so the clocked blocks have settled
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || status_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Game-loop traffic: frames of presses, releases and queries on a small key
    // set, so that keys stay held long enough to repeat, plus some noise
    task automatic queue_frames(int n_items);
        logic [KEY_W-1:0] pool[8];
        logic [KEY_W-1:0] edges[4];
        logic [MODE_W-1:0] m;
        int made;
        int events;
        int pick;
        int i;
        edges[0] = cfg_mod_lo;
        edges[1] = cfg_mod_hi;
        edges[2] = cfg_mouse_lo;
        edges[3] = cfg_mouse_hi;
        for (i = 0; i < 8; i++)
            pool[i] = (i < 4) ? KEY_W'($urandom_range(0, 127))
                              : KEY_W'(edges[i-4] + $urandom_range(0, 2) - 1);
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(MODE_W'($urandom_range(0, 7)), KEY_W'($urandom_range(0, 127)));
                made++;
            end else begin
                push_item(MODE_FRAME_START, pool[$urandom_range(0, 7)]);
                events = $urandom_range(0, 4);
                repeat (events) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        m = MODE_PRESS;
                    else if (pick < 50)
                        m = MODE_RELEASE;
                    else
                        m = MODE_QUERY;
                    push_item(m, pool[$urandom_range(0, 7)]);
                end
                push_item(MODE_FRAME_END, pool[$urandom_range(0, 7)]);
                made += events + 2;
            end
        end
    endtask

    initial begin : stimulus
        int ph_delay[N_PHASES]  = '{2, 31, 1, 7, 0, 0, 3};
        int ph_period[N_PHASES] = '{1, 31, 1, 31, 0, 0, 2};
        int ph_mod_lo[N_PHASES] = '{4, 0, 127, 30, 0, 0, 60};
        int ph_mod_hi[N_PHASES] = '{9, 0, 127, 40, 0, 0, 20};
        int ph_ms_lo[N_PHASES]  = '{120, 127, 0, 41, 0, 0, 100};
        int ph_ms_hi[N_PHASES]  = '{127, 127, 127, 41, 0, 0, 110};
        int ph_items[N_PHASES]  = '{110, 170, 100, 110, 100, 100, 110};
        int ph;
        for (ph = 4; ph <= 5; ph++) begin
            ph_delay[ph] = $urandom_range(1, 31);
            ph_period[ph] = $urandom_range(1, 31);
            ph_mod_lo[ph] = $urandom_range(0, 127);
            ph_mod_hi[ph] = $urandom_range(0, 127);
            ph_ms_lo[ph] = $urandom_range(0, 127);
            ph_ms_hi[ph] = $urandom_range(0, 127);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default registers: key 0 sits in both excluded ranges
        push_item(MODE_QUERY, 0);
        push_item(MODE_PRESS, 127);
        push_item(MODE_PRESS, 0);
        push_item(MODE_FRAME_START, 127);
        push_item(MODE_FRAME_END, 127);
        push_item(MODE_QUERY, 127);
        push_item(MODE_SPARE_LO, 127);
        push_item(MODE_W'(MODE_SPARE_LO + 1), 0);
        push_item(MODE_SPARE_HI, 85);
        push_item(MODE_RELEASE, 127);
        push_item(MODE_PRESS, 42);
        push_item(MODE_FRAME_END, 42);
        push_item(MODE_RELEASE, 42);
        push_item(MODE_FRAME_START, 42);
        wait_idle();

        // Repeat on every frame, modifier range 10..20, empty mouse range
        apply_settings(1, 31, 10, 20, 50, 40);
        push_item(MODE_PRESS, 10);
        push_item(MODE_PRESS, 20);
        push_item(MODE_PRESS, 30);
        push_item(MODE_FRAME_START, 30);
        push_item(MODE_FRAME_END, 30);
        push_item(MODE_FRAME_START, 30);
        push_item(MODE_PRESS, 15);
        push_item(MODE_PRESS, 45);
        push_item(MODE_FRAME_START, 45);
        push_item(MODE_RELEASE, 45);
        push_item(MODE_FRAME_START, 45);
        push_item(MODE_QUERY, 21);
        wait_idle();

        for (ph = 0; ph < N_PHASES; ph++) begin
            apply_settings(ph_delay[ph], ph_period[ph], ph_mod_lo[ph], ph_mod_hi[ph],
                           ph_ms_lo[ph], ph_ms_hi[ph]);
            if (ph == N_PHASES - 1)
                steady_flow = 1'b1;
            queue_frames(ph_items[ph]);
            wait_idle();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: key_state_autorepeat_tracker_core.f
+incdir+sv
sv/ksat_pkg.sv
sv/key_state_autorepeat_tracker_core.sv
test/tb.sv
